/* hdl/neural_activation_unit_macros.svh */
// ----------------------------------------------------------------------------
// neural activation unit assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef NEURAL_ACTIVATION_UNIT_MACROS_SVH
`define NEURAL_ACTIVATION_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define NAU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("activation unit check failed");

// next-cycle implication, live during reset
`define NAU_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("activation unit sequencing check failed");

`endif

/* hdl/nau_pkg.sv */
// ----------------------------------------------------------------------------
// nau_pkg
// constants, function codes and the pipeline item record of the activation unit
// ----------------------------------------------------------------------------
package nau_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_W    = 12;
  localparam int IQ        = 30;
  localparam int EXP_TERMS = 13;
  localparam int LN_TERMS  = 15;
  localparam int ATAN_TERMS = 20;
  localparam int K_MAX     = 23;
  localparam int DIV_BITS  = 31;
  localparam int RECIP_SH  = 37;
  localparam int RW        = RECIP_SH + 1;

  localparam logic [30:0] ONE_Q = 31'h4000_0000;
  localparam logic [34:0] LN2_Q = 35'd744261118;
  localparam logic signed [47:0] PI4_Q = 48'sd843314857;
  localparam logic signed [47:0] PI2_Q = 48'sd1686629713;
  localparam logic signed [DATA_W-1:0] OUT_MAX = DATA_W'((64'd1 << (DATA_W - 1)) - 64'd1);
  localparam logic signed [DATA_W-1:0] OUT_MIN = DATA_W'(64'd1 << (DATA_W - 1));
  localparam logic signed [DATA_W-1:0] OUT_ONE = DATA_W'(64'd1 << FRAC_W);

  typedef enum logic [2:0] {
    SEL_SIGMOID    = 3'd0,
    SEL_SCALED_SIG = 3'd1,
    SEL_SOFTPLUS   = 3'd2,
    SEL_RELU       = 3'd3,
    SEL_STEP       = 3'd4,
    SEL_ATAN       = 3'd5,
    SEL_SOFTSIGN   = 3'd6,
    SEL_SILU       = 3'd7
  } act_sel_t;

  typedef struct packed {
    act_sel_t                sel;
    logic                    neg;
    logic signed [DATA_W-1:0] x;
    logic [34:0]             a;
    logic [4:0]              k;
    logic [29:0]             r;
    logic [30:0]             term;
    logic signed [32:0]      esum;
    logic [30:0]             e;
    logic [63:0]             rem;
    logic [34:0]             den;
    logic [30:0]             q;
    logic                    inv;
    logic                    half;
    logic                    ws;
    logic [29:0]             wm;
    logic [29:0]             w2;
    logic [29:0]             pm;
    logic signed [33:0]      ssum;
    logic signed [47:0]      res;
  } item_t;

endpackage

/* hdl/nau_if.sv */
// ----------------------------------------------------------------------------
// nau_if
// valid/ready channels carrying the input value and the activation result
// ----------------------------------------------------------------------------
interface nau_x_if import nau_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x_in;
  modport source (output valid, output x_in, input ready);
  modport sink (input valid, input x_in, output ready);
endinterface

interface nau_y_if import nau_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] y_out;
  modport source (output valid, output y_out, input ready);
  modport sink (input valid, input y_out, output ready);
endinterface

/* hdl/nau_exp.sv */
// ----------------------------------------------------------------------------
// nau_exp
// exp(-a) in Q30: ln2 range reduction, 13-term series, two stages per term
// ----------------------------------------------------------------------------
module nau_exp import nau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  out_valid,
  output item_t out_item
);

  localparam int NS = 2 * EXP_TERMS + 4;
  localparam int PW = RW + 31;

  item_t          st  [NS];
  item_t          nxt [NS];
  logic [NS-1:0]  vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) st[i] <= nxt[i];
    end
  end

  // k = floor(a / ln2) by parallel threshold compares
  always_comb begin : c_kcount
    logic [4:0] cnt;
    cnt = '0;
    for (int j = 1; j <= K_MAX; j++) begin
      if (in_item.a >= 35'(j) * LN2_Q) cnt = cnt + 5'd1;
    end
    nxt[0]   = in_item;
    nxt[0].k = cnt;
  end

  always_comb begin : c_rem
    logic [34:0] kl;
    kl          = 35'(st[0].k) * LN2_Q;
    nxt[1]      = st[0];
    nxt[1].r    = 30'(st[0].a - kl);
    nxt[1].term = ONE_Q;
    nxt[1].esum = 33'(ONE_Q);
  end

  for (genvar n = 1; n <= EXP_TERMS; n++) begin : g_term
    localparam logic [63:0]   MF = ((64'd1 << RECIP_SH) + 64'(n) - 64'd1) / 64'(n);
    localparam logic [RW-1:0] M  = MF[RW-1:0];

    // term * r, and fold the previous term into the sum
    always_comb begin : c_mul
      logic [60:0] p;
      p = 61'(st[2*n-1].term) * 61'(st[2*n-1].r);
      nxt[2*n]      = st[2*n-1];
      nxt[2*n].term = p[60:30];
      if (n >= 2) begin
        if (((n - 1) % 2) == 1) begin
          nxt[2*n].esum = st[2*n-1].esum - $signed({2'b00, st[2*n-1].term});
        end else begin
          nxt[2*n].esum = st[2*n-1].esum + $signed({2'b00, st[2*n-1].term});
        end
      end
    end

    // divide by n through a reciprocal
    always_comb begin : c_div
      logic [PW-1:0] p;
      p = PW'(st[2*n].term) * PW'(M);
      nxt[2*n+1]      = st[2*n];
      nxt[2*n+1].term = p[RECIP_SH+30:RECIP_SH];
    end
  end

  always_comb begin : c_last
    nxt[NS-2] = st[NS-3];
    if ((EXP_TERMS % 2) == 1) begin
      nxt[NS-2].esum = st[NS-3].esum - $signed({2'b00, st[NS-3].term});
    end else begin
      nxt[NS-2].esum = st[NS-3].esum + $signed({2'b00, st[NS-3].term});
    end
  end

  always_comb begin : c_scale
    nxt[NS-1]   = st[NS-2];
    nxt[NS-1].e = 31'($unsigned(st[NS-2].esum) >> st[NS-2].k);
  end

  assign out_valid = vld[NS-1];
  assign out_item  = st[NS-1];

endmodule

/* hdl/nau_div.sv */
// ----------------------------------------------------------------------------
// nau_div
// restoring divider, one quotient bit per stage, rem / den -> q
// ----------------------------------------------------------------------------
module nau_div import nau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  out_valid,
  output item_t out_item
);

  item_t               st  [DIV_BITS];
  item_t               nxt [DIV_BITS];
  logic [DIV_BITS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_BITS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_BITS; i++) st[i] <= nxt[i];
    end
  end

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_bit
    localparam int B = DIV_BITS - 1 - j;

    always_comb begin : c_step
      item_t       src;
      logic [65:0] d;
      if (j == 0) src = in_item;
      else        src = st[(j == 0) ? 0 : j - 1];
      d      = 66'(src.den) << B;
      nxt[j] = src;
      if (66'(src.rem) >= d) begin
        nxt[j].rem  = 64'(66'(src.rem) - d);
        nxt[j].q[B] = 1'b1;
      end
    end
  end

  assign out_valid = vld[DIV_BITS-1];
  assign out_item  = st[DIV_BITS-1];

endmodule

/* hdl/nau_series.sv */
// ----------------------------------------------------------------------------
// nau_series
// odd-power series in w: atan (alternating, 20 terms) or atanh (15 terms)
// ----------------------------------------------------------------------------
module nau_series import nau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  out_valid,
  output item_t out_item
);

  localparam int NS = ATAN_TERMS + 2;
  localparam int PW = RW + 31;

  item_t         st  [NS];
  item_t         nxt [NS];
  logic [NS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) st[i] <= nxt[i];
    end
  end

  always_comb begin : c_square
    logic [59:0] p;
    p           = 60'(in_item.wm) * 60'(in_item.wm);
    nxt[0]      = in_item;
    nxt[0].w2   = p[59:30];
    nxt[0].pm   = in_item.wm;
    nxt[0].ssum = '0;
    nxt[0].term = '0;
  end

  for (genvar k = 0; k < ATAN_TERMS; k++) begin : g_term
    localparam logic [63:0]   MF = ((64'd1 << RECIP_SH) + 64'(2*k + 1) - 64'd1) / 64'(2*k + 1);
    localparam logic [RW-1:0] M  = MF[RW-1:0];

    // sign-magnitude: p keeps the sign of w, atan alternates per term
    always_comb begin : c_step
      logic [PW-1:0] t;
      logic [59:0]   p;
      logic          is_atan;
      logic          tneg;
      is_atan = (st[k].sel == SEL_ATAN);
      tneg    = st[k].ws ^ (is_atan && (((k - 1) % 2) == 1) && (k >= 1));
      t       = PW'(st[k].pm) * PW'(M);
      p       = 60'(st[k].pm) * 60'(st[k].w2);
      nxt[k+1] = st[k];
      if (tneg) nxt[k+1].ssum = st[k].ssum - $signed({3'b000, st[k].term});
      else      nxt[k+1].ssum = st[k].ssum + $signed({3'b000, st[k].term});
      nxt[k+1].term = t[RECIP_SH+30:RECIP_SH];
      if (!is_atan && (k >= LN_TERMS)) nxt[k+1].term = '0;
      nxt[k+1].pm = p[59:30];
    end
  end

  always_comb begin : c_last
    logic tneg;
    tneg = st[NS-2].ws ^ ((st[NS-2].sel == SEL_ATAN) && (((ATAN_TERMS - 1) % 2) == 1));
    nxt[NS-1] = st[NS-2];
    if (tneg) nxt[NS-1].ssum = st[NS-2].ssum - $signed({3'b000, st[NS-2].term});
    else      nxt[NS-1].ssum = st[NS-2].ssum + $signed({3'b000, st[NS-2].term});
  end

  assign out_valid = vld[NS-1];
  assign out_item  = st[NS-1];

endmodule

/* hdl/neural_activation_unit.sv */
// ----------------------------------------------------------------------------
// neural_activation_unit
// every function takes the same path from input accept to result valid
// throughput: one item per cycle; the whole pipeline advances together and
//   holds while a finished result waits on the output
// reset: synchronous, clears all valid bits and sets the function to sigmoid
// ----------------------------------------------------------------------------
`include "neural_activation_unit_macros.svh"

module neural_activation_unit import nau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        activation_select_we,
  input  logic [2:0]  activation_select,
  nau_x_if.sink       x_ch,
  nau_y_if.source     y_ch
);

  act_sel_t sel_reg;
  act_sel_t out_sel;
  logic     en;

  item_t t0, p1, p2, p3, f1, f2;
  logic  t0_vld, p1_vld, p2_vld, p3_vld, f1_vld, f2_vld;
  item_t ex_o, d1_o, d2_o, se_o;
  logic  ex_vld, d1_vld, d2_vld, se_vld;
  item_t t0_nxt, p1_nxt, p2_nxt, p3_nxt, f1_nxt, f2_nxt;

  assign en         = !y_ch.valid || y_ch.ready;
  assign x_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_reg <= SEL_SIGMOID;
    end else if (activation_select_we) begin
      sel_reg <= act_sel_t'(activation_select);
    end
  end

  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [47:0] v,
                                                          input logic [4:0] s);
    logic [47:0]        m;
    logic [47:0]        h;
    logic [47:0]        t;
    logic signed [47:0] q;
    m = v[47] ? 48'(-v) : 48'(v);
    h = (s == 5'd0) ? '0 : (48'd1 << (s - 5'd1));
    t = (m + h) >> s;
    q = v[47] ? -$signed(t) : $signed(t);
    if (q > 48'(OUT_MAX)) return OUT_MAX;
    if (q < 48'(OUT_MIN)) return OUT_MIN;
    return q[DATA_W-1:0];
  endfunction

  // input stage: argument magnitude in Q30
  always_comb begin : c_in
    logic [15:0] mag;
    mag        = x_ch.x_in[15] ? 16'(-x_ch.x_in) : 16'(x_ch.x_in);
    t0_nxt     = '0;
    t0_nxt.sel = sel_reg;
    t0_nxt.x   = x_ch.x_in;
    t0_nxt.neg = x_ch.x_in[15];
    if (sel_reg == SEL_SCALED_SIG) t0_nxt.a = {mag, 19'b0};
    else                           t0_nxt.a = {1'b0, mag, 18'b0};
  end

  nau_exp u_exp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(t0_vld), .in_item(t0),
    .out_valid(ex_vld), .out_item(ex_o)
  );

  // first division operands
  always_comb begin : c_prep1
    p1_nxt     = ex_o;
    p1_nxt.q   = '0;
    p1_nxt.rem = '0;
    p1_nxt.den = 35'd1;
    p1_nxt.inv = 1'b0;
    unique case (ex_o.sel)
      SEL_SIGMOID, SEL_SCALED_SIG, SEL_SILU: begin
        p1_nxt.rem = 64'd1 << (2 * IQ);
        p1_nxt.den = 35'(ONE_Q) + 35'(ex_o.e);
      end
      SEL_SOFTPLUS: begin
        p1_nxt.rem = 64'(ex_o.e) << IQ;
        p1_nxt.den = (35'(ONE_Q) << 1) + 35'(ex_o.e);
      end
      SEL_ATAN: begin
        // reciprocal argument above one
        if (ex_o.a > 35'(ONE_Q)) begin
          p1_nxt.inv = 1'b1;
          p1_nxt.rem = 64'd1 << (2 * IQ);
          p1_nxt.den = ex_o.a;
        end
      end
      SEL_SOFTSIGN: begin
        p1_nxt.rem = 64'(ex_o.a[33:18]) << IQ;
        p1_nxt.den = (35'd1 << FRAC_W) + 35'(ex_o.a[33:18]);
      end
      default: begin
      end
    endcase
  end

  nau_div u_div1 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(p1_vld), .in_item(p1),
    .out_valid(d1_vld), .out_item(d1_o)
  );

  // second division: atan argument folding above one half
  always_comb begin : c_prep2
    logic [30:0] ap;
    ap          = d1_o.inv ? d1_o.q : d1_o.a[30:0];
    p2_nxt      = d1_o;
    p2_nxt.q    = '0;
    p2_nxt.rem  = '0;
    p2_nxt.den  = 35'd1;
    p2_nxt.half = 1'b0;
    p2_nxt.e    = d1_o.q;
    if (d1_o.sel == SEL_ATAN) begin
      p2_nxt.e = ap;
      if (ap > (ONE_Q >> 1)) begin
        p2_nxt.half = 1'b1;
        p2_nxt.rem  = 64'(ONE_Q - ap) << IQ;
        p2_nxt.den  = 35'(ap) + 35'(ONE_Q);
      end
    end
  end

  nau_div u_div2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(p2_vld), .in_item(p2),
    .out_valid(d2_vld), .out_item(d2_o)
  );

  always_comb begin : c_prep3
    p3_nxt    = d2_o;
    p3_nxt.ws = 1'b0;
    p3_nxt.wm = '0;
    if (d2_o.sel == SEL_SOFTPLUS) begin
      p3_nxt.wm = d2_o.e[29:0];
    end else if (d2_o.sel == SEL_ATAN) begin
      if (d2_o.half) begin
        p3_nxt.ws = 1'b1;
        p3_nxt.wm = d2_o.q[29:0];
      end else begin
        p3_nxt.wm = d2_o.e[29:0];
      end
    end
  end

  nau_series u_series (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(p3_vld), .in_item(p3),
    .out_valid(se_vld), .out_item(se_o)
  );

  // assemble the result per function: Q30, or Q12 for relu and step
  always_comb begin : c_fin1
    logic signed [47:0] e48;
    logic signed [47:0] one48;
    logic signed [47:0] sg;
    logic signed [47:0] x48;
    logic signed [47:0] ss48;
    logic signed [47:0] u;
    logic signed [47:0] r1;
    e48    = $signed(48'(se_o.e));
    one48  = $signed(48'(ONE_Q));
    sg     = se_o.neg ? one48 - e48 : e48;
    x48    = 48'(se_o.x);
    ss48   = 48'(se_o.ssum);
    u      = se_o.half ? PI4_Q + ss48 : ss48;
    r1     = se_o.inv ? PI2_Q - u : u;
    f1_nxt = se_o;
    unique case (se_o.sel)
      SEL_SIGMOID, SEL_SILU: f1_nxt.res = sg;
      SEL_SCALED_SIG:        f1_nxt.res = (sg <<< 1) - one48;
      SEL_SOFTPLUS:          f1_nxt.res = (ss48 <<< 1) + (se_o.neg ? 48'sd0 : (x48 <<< (IQ - FRAC_W)));
      SEL_RELU:              f1_nxt.res = se_o.neg ? 48'sd0 : x48;
      SEL_STEP:              f1_nxt.res = se_o.neg ? 48'sd0 : 48'(OUT_ONE);
      SEL_ATAN:              f1_nxt.res = se_o.neg ? -r1 : r1;
      SEL_SOFTSIGN:          f1_nxt.res = se_o.neg ? -e48 : e48;
    endcase
  end

  always_comb begin : c_fin2
    logic signed [47:0] p;
    p      = f1.x * $signed(f1.res[31:0]);
    f2_nxt = f1;
    if (f1.sel == SEL_SILU) f2_nxt.res = p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_vld     <= 1'b0;
      p1_vld     <= 1'b0;
      p2_vld     <= 1'b0;
      p3_vld     <= 1'b0;
      f1_vld     <= 1'b0;
      f2_vld     <= 1'b0;
      y_ch.valid <= 1'b0;
    end else if (en) begin
      t0_vld     <= x_ch.valid;
      p1_vld     <= ex_vld;
      p2_vld     <= d1_vld;
      p3_vld     <= d2_vld;
      f1_vld     <= se_vld;
      f2_vld     <= f1_vld;
      y_ch.valid <= f2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0      <= t0_nxt;
      p1      <= p1_nxt;
      p2      <= p2_nxt;
      p3      <= p3_nxt;
      f1      <= f1_nxt;
      f2      <= f2_nxt;
      out_sel <= f2.sel;
      unique case (f2.sel)
        SEL_SILU:           y_ch.y_out <= round_sat(f2.res, 5'(IQ));
        SEL_RELU, SEL_STEP: y_ch.y_out <= round_sat(f2.res, 5'd0);
        default:            y_ch.y_out <= round_sat(f2.res, 5'(IQ - FRAC_W));
      endcase
    end
  end

  `NAU_ASSERT_IMPL(a_relu_nonneg, clk, rst, y_ch.valid && out_sel == SEL_RELU, !y_ch.y_out[DATA_W-1])
  `NAU_ASSERT_IMPL(a_step_levels, clk, rst, y_ch.valid && out_sel == SEL_STEP, y_ch.y_out == '0 || y_ch.y_out == OUT_ONE)
  `NAU_ASSERT_IMPL(a_sigmoid_range, clk, rst, y_ch.valid && out_sel == SEL_SIGMOID, !y_ch.y_out[DATA_W-1] && y_ch.y_out <= OUT_ONE)
  `NAU_ASSERT_NEXT(a_reset_empty, clk, rst, !y_ch.valid)

endmodule
